// ===== rtl/core/igof_pkg.sv =====
// Package for the IMU gradient orientation filter: constants, codes and the multiply-accumulate program.
`default_nettype none
package igof_pkg;

  localparam int unsigned QuatFracBitsDef = 30;
  localparam logic [31:0] SamplePeriodRst = 32'd21474836;
  localparam logic [30:0] CorrectionGainRst = 31'd81147931;

  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned VecW = 50;
  localparam int unsigned MulW = 34;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned SaccW = VecW + 32;
  localparam int unsigned ScaleSplit = 24;
  localparam int unsigned RateShift = 17;
  localparam int unsigned GainShift = 30;

  localparam logic [4:0] StepFEnd = 5'd5;
  localparam logic [4:0] StepGEnd = 5'd15;
  localparam logic [4:0] StepDot = 5'd16;
  localparam logic [4:0] StepLast = 5'd31;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SAMPLE_PERIOD   = 1'b0,
    REG_CORRECTION_GAIN = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    A_Q0, A_Q1, A_Q2, A_Q3, A_BETA
  } src_a_e;

  typedef enum logic [3:0] {
    B_Q1, B_Q2, B_Q3, B_F1, B_F2, B_F3, B_WX, B_WY, B_WZ, B_G0, B_G1, B_G2, B_G3
  } src_b_e;

  typedef enum logic [1:0] {
    SH_QF, SH_RATE, SH_GAIN
  } shift_e;

  typedef enum logic [1:0] {
    CF_P1, CF_M1, CF_P2, CF_M2
  } coef_e;

  typedef struct packed {
    src_a_e     a;
    src_b_e     b;
    shift_e     sh;
    coef_e      cf;
    logic [1:0] dst;
  } uop_t;

  function automatic uop_t mk_uop(src_a_e a, src_b_e b, shift_e sh, coef_e cf,
                                  logic [1:0] dst);
    uop_t u;
    u.a = a;
    u.b = b;
    u.sh = sh;
    u.cf = cf;
    u.dst = dst;
    return u;
  endfunction

  // f terms, gradient, gyro rate, then gain times unit gradient
  function automatic uop_t ucode(logic [4:0] step);
    uop_t u;
    case (step)
      5'd0:  u = mk_uop(A_Q1, B_Q3, SH_QF, CF_P2, 2'd0);
      5'd1:  u = mk_uop(A_Q0, B_Q2, SH_QF, CF_M2, 2'd0);
      5'd2:  u = mk_uop(A_Q0, B_Q1, SH_QF, CF_P2, 2'd1);
      5'd3:  u = mk_uop(A_Q2, B_Q3, SH_QF, CF_P2, 2'd1);
      5'd4:  u = mk_uop(A_Q1, B_Q1, SH_QF, CF_M2, 2'd2);
      5'd5:  u = mk_uop(A_Q2, B_Q2, SH_QF, CF_M2, 2'd2);
      5'd6:  u = mk_uop(A_Q1, B_F2, SH_QF, CF_P1, 2'd0);
      5'd7:  u = mk_uop(A_Q2, B_F1, SH_QF, CF_M1, 2'd0);
      5'd8:  u = mk_uop(A_Q3, B_F1, SH_QF, CF_P1, 2'd1);
      5'd9:  u = mk_uop(A_Q0, B_F2, SH_QF, CF_P1, 2'd1);
      5'd10: u = mk_uop(A_Q1, B_F3, SH_QF, CF_M2, 2'd1);
      5'd11: u = mk_uop(A_Q3, B_F2, SH_QF, CF_P1, 2'd2);
      5'd12: u = mk_uop(A_Q2, B_F3, SH_QF, CF_M2, 2'd2);
      5'd13: u = mk_uop(A_Q0, B_F1, SH_QF, CF_M1, 2'd2);
      5'd14: u = mk_uop(A_Q1, B_F1, SH_QF, CF_P1, 2'd3);
      5'd15: u = mk_uop(A_Q2, B_F2, SH_QF, CF_P1, 2'd3);
      5'd16: u = mk_uop(A_Q1, B_WX, SH_RATE, CF_M1, 2'd0);
      5'd17: u = mk_uop(A_Q2, B_WY, SH_RATE, CF_M1, 2'd0);
      5'd18: u = mk_uop(A_Q3, B_WZ, SH_RATE, CF_M1, 2'd0);
      5'd19: u = mk_uop(A_Q0, B_WX, SH_RATE, CF_P1, 2'd1);
      5'd20: u = mk_uop(A_Q2, B_WZ, SH_RATE, CF_P1, 2'd1);
      5'd21: u = mk_uop(A_Q3, B_WY, SH_RATE, CF_M1, 2'd1);
      5'd22: u = mk_uop(A_Q0, B_WY, SH_RATE, CF_P1, 2'd2);
      5'd23: u = mk_uop(A_Q1, B_WZ, SH_RATE, CF_M1, 2'd2);
      5'd24: u = mk_uop(A_Q3, B_WX, SH_RATE, CF_P1, 2'd2);
      5'd25: u = mk_uop(A_Q0, B_WZ, SH_RATE, CF_P1, 2'd3);
      5'd26: u = mk_uop(A_Q1, B_WY, SH_RATE, CF_P1, 2'd3);
      5'd27: u = mk_uop(A_Q2, B_WX, SH_RATE, CF_M1, 2'd3);
      5'd28: u = mk_uop(A_BETA, B_G0, SH_GAIN, CF_M1, 2'd0);
      5'd29: u = mk_uop(A_BETA, B_G1, SH_GAIN, CF_M1, 2'd1);
      5'd30: u = mk_uop(A_BETA, B_G2, SH_GAIN, CF_M1, 2'd2);
      5'd31: u = mk_uop(A_BETA, B_G3, SH_GAIN, CF_M1, 2'd3);
      default: u = mk_uop(A_Q0, B_Q1, SH_QF, CF_P1, 2'd0);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/imu_gradient_orientation_filter.sv =====
// Gradient-descent IMU orientation filter: sequencer around one shared multiplier.
//
// Input channel (in_valid_i/in_ready_o) takes one word of gyro rate and raw
// accelerometer reading; output channel (out_valid_o/out_ready_i) returns the
// updated quaternion in Q2.F plus a flag for a dropped gradient correction.
// Config writes (cfg_we_i, cfg_addr_i, cfg_wdata_i) take effect at once and
// belong in idle time.
// Words are computed one at a time. One with the correction applied runs three
// vector normalizations (abs, normalizing shifts, squares, square root, four
// divides), a 32-step multiply-accumulate program on the single 34x34
// multiplier, and time-step scaling. A zero accelerometer vector skips the
// first two normalizations and half the program; a vanishing gradient skips
// the second one.
// in_ready_o is high only while the sequencer is idle. A finished word sits in
// the output register; the next word is accepted and computed meanwhile and
// waits at its end until the output register is free.
// Reset sets the quaternion to (1, 0, 0, 0) and the registers to their
// defaults, and clears the output valid.
`default_nettype none
module imu_gradient_orientation_filter #(
  parameter int unsigned QUAT_FRAC_BITS = igof_pkg::QuatFracBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [igof_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [31:0]                   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [31:0]            gyro_x_i,
  input  wire logic signed [31:0]            gyro_y_i,
  input  wire logic signed [31:0]            gyro_z_i,
  input  wire logic signed [15:0]            accel_x_i,
  input  wire logic signed [15:0]            accel_y_i,
  input  wire logic signed [15:0]            accel_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [31:0]                 quat_w_o,
  output logic signed [31:0]                 quat_x_o,
  output logic signed [31:0]                 quat_y_o,
  output logic signed [31:0]                 quat_z_o,
  output logic                               correction_skipped_o
);
  import igof_pkg::*;

  localparam logic signed [31:0] QuatOne = 32'sd1 <<< QUAT_FRAC_BITS;
  localparam logic signed [31:0] QuatNeg = -QuatOne;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_ABS    = 10'b00_0000_0010,
    ST_NORM   = 10'b00_0000_0100,
    ST_SQUARE = 10'b00_0000_1000,
    ST_SQRT   = 10'b00_0001_0000,
    ST_DLOAD  = 10'b00_0010_0000,
    ST_DIV    = 10'b00_0100_0000,
    ST_MAC    = 10'b00_1000_0000,
    ST_SCALE  = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    CALL_ACCEL, CALL_GRAD, CALL_QUAT
  } call_e;

  // control and state registers
  state_e state_q, state_d;
  call_e  call_q, call_d;
  logic [4:0] step_q, step_d;
  logic [1:0] ph_q, ph_d;
  logic [1:0] idx_q, idx_d;
  logic [4:0] cnt_q, cnt_d;
  logic skip_q, skip_d;
  logic out_valid_q, out_valid_d;
  logic [31:0] sp_q, sp_d;
  logic [30:0] gain_q, gain_d;
  logic signed [31:0] q_q [4];
  logic signed [31:0] q_d [4];

  // datapath registers
  logic signed [31:0]     w_q [3];
  logic signed [31:0]     w_d [3];
  logic signed [MulW-1:0] f_q [3];
  logic signed [MulW-1:0] f_d [3];
  logic signed [VecW-1:0] acc_q [4];
  logic signed [VecW-1:0] acc_d [4];
  logic signed [VecW-1:0] vec_q [4];
  logic signed [VecW-1:0] vec_d [4];
  logic [VecW-1:0]        mag_q [4];
  logic [VecW-1:0]        mag_d [4];
  logic [3:0]             neg_q, neg_d;
  logic signed [31:0]     uvec_q [4];
  logic signed [31:0]     uvec_d [4];
  logic signed [ProdW-1:0] prod_q;
  logic [SaccW-1:0]       sacc_q, sacc_d;
  logic [63:0]            sum_q, sum_d;
  logic [63:0]            sqn_q, sqn_d;
  logic [63:0]            sqr_q, sqr_d;
  logic [31:0]            r_q, r_d;
  logic [31:0]            rem_q, rem_d;
  logic [31:0]            qt_q, qt_d;
  logic signed [31:0]     oq_q [4];
  logic signed [31:0]     oq_d [4];
  logic                   oskip_q, oskip_d;

  // shared multiplier
  logic [MulW-1:0]         mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  assign mul_p = $signed(mul_a) * $signed(mul_b);

  uop_t uop;
  assign uop = ucode(step_q);

  logic [1:0]             acc_sel;
  logic signed [VecW-1:0] acc_rd;
  logic                   sneg;
  logic [VecW-1:0]        mag_s;
  assign acc_sel = (state_q == ST_SCALE) ? idx_q : uop.dst;
  assign acc_rd  = acc_q[acc_sel];
  assign sneg    = acc_rd[VecW-1];
  assign mag_s   = sneg ? $unsigned(-acc_rd) : $unsigned(acc_rd);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQUARE: begin
        mul_a = MulW'(mag_q[idx_q][30:0]);
        mul_b = MulW'(mag_q[idx_q][30:0]);
      end
      ST_SCALE: begin
        mul_a = (ph_q == 2'd0) ? MulW'(mag_s[VecW-1:ScaleSplit])
                               : MulW'(mag_s[ScaleSplit-1:0]);
        mul_b = MulW'(sp_q);
      end
      ST_MAC: begin
        case (uop.a)
          A_Q0:    mul_a = MulW'(q_q[0]);
          A_Q1:    mul_a = MulW'(q_q[1]);
          A_Q2:    mul_a = MulW'(q_q[2]);
          A_Q3:    mul_a = MulW'(q_q[3]);
          A_BETA:  mul_a = MulW'(gain_q);
          default: mul_a = '0;
        endcase
        case (uop.b)
          B_Q1:    mul_b = MulW'(q_q[1]);
          B_Q2:    mul_b = MulW'(q_q[2]);
          B_Q3:    mul_b = MulW'(q_q[3]);
          B_F1:    mul_b = f_q[0];
          B_F2:    mul_b = f_q[1];
          B_F3:    mul_b = f_q[2];
          B_WX:    mul_b = MulW'(w_q[0]);
          B_WY:    mul_b = MulW'(w_q[1]);
          B_WZ:    mul_b = MulW'(w_q[2]);
          B_G0:    mul_b = MulW'(uvec_q[0]);
          B_G1:    mul_b = MulW'(uvec_q[1]);
          B_G2:    mul_b = MulW'(uvec_q[2]);
          B_G3:    mul_b = MulW'(uvec_q[3]);
          default: mul_b = '0;
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // scaled, signed term of the multiply-accumulate program
  logic signed [ProdW-1:0] shd;
  logic signed [VecW-1:0]  term, termc;
  always_comb begin
    case (uop.sh)
      SH_QF:   shd = prod_q >>> QUAT_FRAC_BITS;
      SH_RATE: shd = prod_q >>> RateShift;
      SH_GAIN: shd = prod_q >>> GainShift;
      default: shd = prod_q;
    endcase
    term = shd[VecW-1:0];
    case (uop.cf)
      CF_P1:   termc = term;
      CF_M1:   termc = -term;
      CF_P2:   termc = term <<< 1;
      CF_M2:   termc = -(term <<< 1);
      default: termc = term;
    endcase
  end

  // unit-vector helpers
  logic [VecW-1:0] mag_all;
  assign mag_all = mag_q[0] | mag_q[1] | mag_q[2] | mag_q[3];

  logic [63:0] sq_bit, sq_t, sqr_n;
  logic        sq_ge;
  assign sq_bit = 64'd1 << {cnt_q, 1'b0};
  assign sq_t   = sqr_q + sq_bit;
  assign sq_ge  = sqn_q >= sq_t;
  assign sqr_n  = sq_ge ? ((sqr_q >> 1) + sq_bit) : (sqr_q >> 1);

  logic [32:0] dv_t, dv_sub;
  logic        dv_ge;
  logic [31:0] qt_n, qt_c;
  logic [63:0] dv_num;
  assign dv_t   = {rem_q, qt_q[31]};
  assign dv_ge  = dv_t >= {1'b0, r_q};
  assign dv_sub = dv_t - {1'b0, r_q};
  assign qt_n   = {qt_q[30:0], dv_ge};
  assign qt_c   = (qt_n > $unsigned(QuatOne)) ? $unsigned(QuatOne) : qt_n;
  assign dv_num = 64'(mag_q[idx_q][30:0]) << QUAT_FRAC_BITS;

  logic signed [VecW-1:0] sc_q, sc_p;
  assign sc_q = VecW'(q_q[idx_q]);
  assign sc_p = $signed(sacc_q[SaccW-1:32]);

  logic unit_exit, unit_ok;

  always_comb begin
    state_d = state_q;
    call_d = call_q;
    step_d = step_q;
    ph_d = ph_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    skip_d = skip_q;
    sp_d = sp_q;
    gain_d = gain_q;
    q_d = q_q;
    w_d = w_q;
    f_d = f_q;
    acc_d = acc_q;
    vec_d = vec_q;
    mag_d = mag_q;
    neg_d = neg_q;
    uvec_d = uvec_q;
    sacc_d = sacc_q;
    sum_d = sum_q;
    sqn_d = sqn_q;
    sqr_d = sqr_q;
    r_d = r_q;
    rem_d = rem_q;
    qt_d = qt_q;
    oq_d = oq_q;
    oskip_d = oskip_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    unit_exit = 1'b0;
    unit_ok = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_SAMPLE_PERIOD:   sp_d = cfg_wdata_i;
        REG_CORRECTION_GAIN: gain_d = cfg_wdata_i[30:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          w_d[0] = gyro_x_i;
          w_d[1] = gyro_y_i;
          w_d[2] = gyro_z_i;
          vec_d[0] = VecW'(accel_x_i);
          vec_d[1] = VecW'(accel_y_i);
          vec_d[2] = VecW'(accel_z_i);
          vec_d[3] = '0;
          call_d = CALL_ACCEL;
          state_d = ST_ABS;
        end
      end
      ST_ABS: begin
        for (int i = 0; i < 4; i++) begin
          neg_d[i] = vec_q[i][VecW-1];
          mag_d[i] = vec_q[i][VecW-1] ? $unsigned(-vec_q[i]) : $unsigned(vec_q[i]);
        end
        state_d = ST_NORM;
      end
      ST_NORM: begin
        // bring the largest magnitude into [2^30, 2^31)
        if (mag_all == '0) begin
          unit_exit = 1'b1;
        end else if (|mag_all[VecW-1:31]) begin
          for (int i = 0; i < 4; i++) mag_d[i] = mag_q[i] >> 1;
        end else if (!mag_all[30]) begin
          for (int i = 0; i < 4; i++) mag_d[i] = mag_q[i] << 1;
        end else begin
          sum_d = '0;
          idx_d = '0;
          ph_d = '0;
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          ph_d = 2'd0;
          sum_d = sum_q + prod_q[63:0];
          if (idx_q == 2'd3) begin
            sqn_d = sum_d;
            sqr_d = '0;
            cnt_d = 5'd31;
            idx_d = '0;
            state_d = ST_SQRT;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      ST_SQRT: begin
        if (sq_ge) sqn_d = sqn_q - sq_t;
        sqr_d = sqr_n;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          r_d = sqr_n[31:0];
          idx_d = '0;
          state_d = ST_DLOAD;
        end
      end
      ST_DLOAD: begin
        rem_d = dv_num[63:32];
        qt_d = dv_num[31:0];
        cnt_d = 5'd31;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = dv_ge ? dv_sub[31:0] : dv_t[31:0];
        qt_d = qt_n;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          uvec_d[idx_q] = neg_q[idx_q] ? -$signed(qt_c) : $signed(qt_c);
          if (idx_q == 2'd3) begin
            unit_exit = 1'b1;
            unit_ok = 1'b1;
          end else begin
            idx_d = idx_q + 2'd1;
            state_d = ST_DLOAD;
          end
        end
      end
      ST_MAC: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          ph_d = 2'd0;
          acc_d[uop.dst] = acc_rd + termc;
          step_d = step_q + 5'd1;
          if (step_q == StepFEnd) begin
            for (int i = 0; i < 3; i++) f_d[i] = MulW'(acc_d[i]);
            for (int i = 0; i < 4; i++) acc_d[i] = '0;
          end else if (step_q == StepGEnd) begin
            vec_d = acc_d;
            call_d = CALL_GRAD;
            state_d = ST_ABS;
          end else if (step_q == StepLast) begin
            idx_d = '0;
            state_d = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        // |d| * dt split in two partial products, summed, then >> 32
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd1) begin
          sacc_d = SaccW'($unsigned(prod_q)) << ScaleSplit;
        end else if (ph_q == 2'd2) begin
          sacc_d = sacc_q + SaccW'($unsigned(prod_q));
        end else if (ph_q == 2'd3) begin
          vec_d[idx_q] = sneg ? (sc_q - sc_p) : (sc_q + sc_p);
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            call_d = CALL_QUAT;
            state_d = ST_ABS;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          oq_d = q_q;
          oskip_d = skip_q;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (unit_exit) begin
      if (!unit_ok) begin
        for (int i = 0; i < 4; i++) uvec_d[i] = '0;
      end
      ph_d = '0;
      case (call_q)
        CALL_ACCEL: begin
          state_d = ST_MAC;
          if (unit_ok) begin
            acc_d[0] = -VecW'(uvec_d[0]);
            acc_d[1] = -VecW'(uvec_d[1]);
            acc_d[2] = VecW'(QuatOne) - VecW'(uvec_d[2]);
            acc_d[3] = '0;
            step_d = '0;
            skip_d = 1'b0;
          end else begin
            for (int i = 0; i < 4; i++) acc_d[i] = '0;
            step_d = StepDot;
            skip_d = 1'b1;
          end
        end
        CALL_GRAD: begin
          state_d = ST_MAC;
          for (int i = 0; i < 4; i++) acc_d[i] = '0;
          step_d = StepDot;
          skip_d = ~unit_ok;
        end
        CALL_QUAT: begin
          // a zero result keeps the stored quaternion
          if (unit_ok) q_d = uvec_d;
          state_d = ST_DONE;
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
      sp_q <= SamplePeriodRst;
      gain_q <= CorrectionGainRst;
      q_q[0] <= QuatOne;
      q_q[1] <= '0;
      q_q[2] <= '0;
      q_q[3] <= '0;
      call_q <= CALL_ACCEL;
      step_q <= '0;
      ph_q <= '0;
      idx_q <= '0;
      cnt_q <= '0;
      skip_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      sp_q <= sp_d;
      gain_q <= gain_d;
      q_q <= q_d;
      call_q <= call_d;
      step_q <= step_d;
      ph_q <= ph_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    f_q <= f_d;
    acc_q <= acc_d;
    vec_q <= vec_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    uvec_q <= uvec_d;
    prod_q <= mul_p;
    sacc_q <= sacc_d;
    sum_q <= sum_d;
    sqn_q <= sqn_d;
    sqr_q <= sqr_d;
    r_q <= r_d;
    rem_q <= rem_d;
    qt_q <= qt_d;
    oq_q <= oq_d;
    oskip_q <= oskip_d;
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign quat_w_o = oq_q[0];
  assign quat_x_o = oq_q[1];
  assign quat_y_o = oq_q[2];
  assign quat_z_o = oq_q[3];
  assign correction_skipped_o = oskip_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accepted a word while busy");

  a_div_rem_below_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < r_q))
    else $error("divider remainder not below root");

  a_quat_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_q[0] <= QuatOne) && (q_q[0] >= QuatNeg) && (q_q[1] <= QuatOne) &&
    (q_q[1] >= QuatNeg) && (q_q[2] <= QuatOne) && (q_q[2] >= QuatNeg) &&
    (q_q[3] <= QuatOne) && (q_q[3] >= QuatNeg))
    else $error("stored quaternion out of unit range");

  a_skip_zero_grad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC && step_q >= StepDot && skip_q) |->
    (uvec_q[0] == '0 && uvec_q[1] == '0 && uvec_q[2] == '0 && uvec_q[3] == '0))
    else $error("gradient not cleared on dropped correction");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the IMU gradient orientation filter.
`timescale 1ns / 1ps
module testbench;
  import igof_pkg::*;

  typedef longint vec4_t[4];

  typedef struct {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               skipped;
  } quat_word_t;

  localparam int unsigned FracBits = QuatFracBitsDef;
  localparam int unsigned StallLimit = 40000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] gyro_x_i = '0, gyro_y_i = '0, gyro_z_i = '0;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;
  logic correction_skipped_o;

  imu_gradient_orientation_filter u_top (.*);

  always #10 clk_i = ~clk_i;

  // filter state mirrored for prediction
  longint          orient[4];
  longint unsigned period_q32;
  longint unsigned gain_q30;

  quat_word_t expected_quats[$];
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned skipped_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  function automatic longint mul_floor(longint a, longint b, int s);
    return (a * b) >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit make_unit(input vec4_t v, output vec4_t u);
    longint unsigned mag[4];
    longint unsigned all, sum, r, q, one;
    bit neg[4];
    all = 0;
    sum = 0;
    one = 64'd1 << FracBits;
    u = '{0, 0, 0, 0};
    for (int i = 0; i < 4; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      all |= mag[i];
    end
    if (all == 0) return 1'b0;
    while (all >= (64'd1 << 31)) begin
      all >>= 1;
      for (int i = 0; i < 4; i++) mag[i] >>= 1;
    end
    while (all < (64'd1 << 30)) begin
      all <<= 1;
      for (int i = 0; i < 4; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
    r = int_sqrt(sum);
    for (int i = 0; i < 4; i++) begin
      q = (mag[i] << FracBits) / r;
      if (q > one) q = one;
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint period_step(longint d);
    longint unsigned m, hi, lo, p;
    m = (d < 0) ? -d : d;
    hi = (period_q32 >> 16) & 64'hFFFF;
    lo = period_q32 & 64'hFFFF;
    p = (m * hi + ((m * lo) >> 16)) >> 16;
    return (d < 0) ? -longint'(p) : longint'(p);
  endfunction

  // advances the mirrored orientation by one sample
  function automatic quat_word_t update_orientation(longint wx, longint wy, longint wz,
                                                    longint ax, longint ay, longint az);
    longint one, q1, q2, q3, q4, f1, f2, f3;
    vec4_t acc, an, gr, g, rate, nq, u;
    quat_word_t res;
    one = 64'd1 << FracBits;
    q1 = orient[0]; q2 = orient[1]; q3 = orient[2]; q4 = orient[3];
    g = '{0, 0, 0, 0};
    res.skipped = 1'b1;
    acc = '{ax, ay, az, 0};
    if (make_unit(acc, an)) begin
      f1 = 2 * (mul_floor(q2, q4, FracBits) - mul_floor(q1, q3, FracBits)) - an[0];
      f2 = 2 * (mul_floor(q1, q2, FracBits) + mul_floor(q3, q4, FracBits)) - an[1];
      f3 = one - 2 * (mul_floor(q2, q2, FracBits) + mul_floor(q3, q3, FracBits)) - an[2];
      gr[0] = mul_floor(q2, f2, FracBits) - mul_floor(q3, f1, FracBits);
      gr[1] = mul_floor(q4, f1, FracBits) + mul_floor(q1, f2, FracBits)
            - 2 * mul_floor(q2, f3, FracBits);
      gr[2] = mul_floor(q4, f2, FracBits) - 2 * mul_floor(q3, f3, FracBits)
            - mul_floor(q1, f1, FracBits);
      gr[3] = mul_floor(q2, f1, FracBits) + mul_floor(q3, f2, FracBits);
      if (make_unit(gr, g)) res.skipped = 1'b0;
      else g = '{0, 0, 0, 0};
    end
    rate[0] = -mul_floor(q2, wx, 17) - mul_floor(q3, wy, 17) - mul_floor(q4, wz, 17);
    rate[1] = mul_floor(q1, wx, 17) + mul_floor(q3, wz, 17) - mul_floor(q4, wy, 17);
    rate[2] = mul_floor(q1, wy, 17) - mul_floor(q2, wz, 17) + mul_floor(q4, wx, 17);
    rate[3] = mul_floor(q1, wz, 17) + mul_floor(q2, wy, 17) - mul_floor(q3, wx, 17);
    nq = '{q1, q2, q3, q4};
    for (int i = 0; i < 4; i++)
      nq[i] += period_step(rate[i] - mul_floor(longint'(gain_q30), g[i], 30));
    // an all-zero result keeps the old orientation
    if (make_unit(nq, u))
      for (int i = 0; i < 4; i++) orient[i] = u[i];
    res.w = orient[0][31:0];
    res.x = orient[1][31:0];
    res.y = orient[2][31:0];
    res.z = orient[3][31:0];
    return res;
  endfunction

  task automatic send_word(logic signed [31:0] wx, logic signed [31:0] wy,
                           logic signed [31:0] wz, logic signed [15:0] ax,
                           logic signed [15:0] ay, logic signed [15:0] az);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    gyro_x_i <= wx; gyro_y_i <= wy; gyro_z_i <= wz;
    accel_x_i <= ax; accel_y_i <= ay; accel_z_i <= az;
    do @(posedge clk_i); while (!in_ready_o);
    expected_quats.push_back(update_orientation(wx, wy, wz, ax, ay, az));
    words_sent++;
  endtask

  task automatic drain;
    // drop valid so the last word is not taken twice
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SAMPLE_PERIOD) period_q32 = value;
    else gain_q30 = value & 32'h7FFF_FFFF;
  endtask

  task automatic send_random_word;
    logic signed [31:0] w[3];
    logic signed [15:0] a[3];
    for (int i = 0; i < 3; i++) begin
      // mostly realistic rates, sometimes the full range
      if ($urandom_range(9) < 7) w[i] = $signed($urandom_range(0, 2 ** 19)) - 2 ** 18;
      else w[i] = $urandom;
      case ($urandom_range(9))
        0: a[i] = '0;
        1: a[i] = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        default: a[i] = $urandom;
      endcase
    end
    if ($urandom_range(19) == 0) a = '{16'sd0, 16'sd0, 16'sd0};
    send_word(w[0], w[1], w[2], a[0], a[1], a[2]);
  endtask

  task automatic test_directed;
    // level, aligned with gravity at reset: gradient vanishes
    send_word(0, 0, 0, 0, 0, 16'sd1000);
    send_word(0, 0, 0, 0, 0, 0);
    send_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_word(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              16'sh8000, 16'sh8000, 16'sh8000);
    send_word(32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 16'sh8000, 0, 16'sh7FFF);
    send_word(-1, 1, 0, 1, -1, 0);
    send_word(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 16'sh8000, 0);
    write_reg(REG_SAMPLE_PERIOD, 32'd0);
    send_word(32'sh0004_0000, 0, 0, 16'sh4000, 0, 0);
    send_word(0, 0, 0, 0, 0, 0);
    write_reg(REG_CORRECTION_GAIN, 31'd0);
    write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
    send_word(32'sh0003_0000, 32'sh0001_0000, 0, 0, 16'sh7FFF, 0);
    send_word(32'sh8000_0000, 32'sh7FFF_FFFF, -1, 16'sh8000, 0, 0);
    write_reg(REG_CORRECTION_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_SAMPLE_PERIOD, 32'd1);
    send_word(0, 0, 0, 16'sh1234, -16'sh0321, 16'sh4000);
    write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
    send_word(32'sh0000_1000, 0, 0, 0, 16'sh8000, 16'sh7FFF);
    send_word(0, 0, 0, 0, 0, 16'sh0001);
    write_reg(REG_CORRECTION_GAIN, 31'h4000_0000);
    write_reg(REG_SAMPLE_PERIOD, SamplePeriodRst);
    send_word(0, 32'sh0001_0000, 0, 16'sh0100, 16'sh0100, 16'sh0100);
  endtask

  task automatic test_random(int unsigned n, int unsigned s_idle, int unsigned r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n; i++) send_random_word();
  endtask

  task automatic test_config_sweep(int unsigned n);
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: write_reg(REG_SAMPLE_PERIOD, $urandom_range(1, 32'h0100_0000));
        1: write_reg(REG_SAMPLE_PERIOD, $urandom);
        default: write_reg(REG_SAMPLE_PERIOD, $urandom_range(1, 32'h0400_0000));
      endcase
      write_reg(REG_CORRECTION_GAIN, $urandom_range(0, 31'h4000_0000));
      test_random(n, 0, 0);
    end
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("%0t: watchdog expired, %0d words outstanding", $time,
               expected_quats.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    quat_word_t exp_q;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: unexpected word w=%0d x=%0d y=%0d z=%0d", $time,
                 quat_w_o, quat_x_o, quat_y_o, quat_z_o);
        errors++;
      end else begin
        exp_q = expected_quats.pop_front();
        words_checked++;
        if (exp_q.skipped) skipped_seen++;
        if (quat_w_o !== exp_q.w || quat_x_o !== exp_q.x || quat_y_o !== exp_q.y ||
            quat_z_o !== exp_q.z || correction_skipped_o !== exp_q.skipped) begin
          $display("%0t: mismatch expected (%0d %0d %0d %0d skip %0b) got (%0d %0d %0d %0d skip %0b)",
                   $time, exp_q.w, exp_q.x, exp_q.y, exp_q.z, exp_q.skipped,
                   quat_w_o, quat_x_o, quat_y_o, quat_z_o, correction_skipped_o);
          errors++;
        end
      end
    end
  end

  initial begin
    orient = '{longint'(1) << FracBits, 0, 0, 0};
    period_q32 = SamplePeriodRst;
    gain_q30 = CorrectionGainRst;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    recv_idle_pct = 0;
    test_directed();
    write_reg(REG_CORRECTION_GAIN, CorrectionGainRst);
    test_random(300, 29, 58);
    write_reg(REG_SAMPLE_PERIOD, 32'h0080_0000);
    test_random(300, 58, 29);
    test_config_sweep(80);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain();
    $display("Sent %0d words, checked %0d quaternions, %0d with correction dropped.",
             words_sent, words_checked, skipped_seen);
    $display("Covered both idle patterns, no idling, and period/gain extremes.");
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d errors, %0d words never returned", errors, expected_quats.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/igof_pkg.sv
rtl/core/imu_gradient_orientation_filter.sv
tb/testbench.sv
